// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// check prop on every clk edge outside reset
`define CHK_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// expr must never be true
`define CHK_NEVER(lbl, expr, msg) \
	`CHK_ALWAYS(lbl, !(expr), msg)

`else

`define CHK_ALWAYS(lbl, prop, msg)
`define CHK_NEVER(lbl, expr, msg)

`endif

`endif

// ===== src/i2cm_pkg.sv =====
package i2cm_pkg;

	localparam int CFG_W = 16;
	localparam int PH_W  = 5;

	localparam logic [1:0] ACT_START = 2'd0;
	localparam logic [1:0] ACT_STOP  = 2'd1;
	localparam logic [1:0] ACT_WRITE = 2'd2;
	localparam logic [1:0] ACT_READ  = 2'd3;

	localparam logic [0:0] REG_START_TICKS = 1'd0;
	localparam logic [0:0] REG_BIT_TICKS   = 1'd1;

	localparam logic [PH_W-1:0] PH_IDLE    = 5'd0;
	localparam logic [PH_W-1:0] PH_ST_A    = 5'd1;
	localparam logic [PH_W-1:0] PH_ST_B    = 5'd2;
	localparam logic [PH_W-1:0] PH_ST_C    = 5'd3;
	localparam logic [PH_W-1:0] PH_ST_D    = 5'd4;
	localparam logic [PH_W-1:0] PH_SP_A    = 5'd5;
	localparam logic [PH_W-1:0] PH_SP_B    = 5'd6;
	localparam logic [PH_W-1:0] PH_SP_C    = 5'd7;
	localparam logic [PH_W-1:0] PH_SP_D    = 5'd8;
	localparam logic [PH_W-1:0] PH_WR_SET  = 5'd9;
	localparam logic [PH_W-1:0] PH_WR_HIGH = 5'd10;
	localparam logic [PH_W-1:0] PH_WR_LOW  = 5'd11;
	localparam logic [PH_W-1:0] PH_WA_REL  = 5'd12;
	localparam logic [PH_W-1:0] PH_WA_HIGH = 5'd13;
	localparam logic [PH_W-1:0] PH_WA_LOW  = 5'd14;
	localparam logic [PH_W-1:0] PH_RD_HIGH = 5'd15;
	localparam logic [PH_W-1:0] PH_RD_LOW  = 5'd16;
	localparam logic [PH_W-1:0] PH_RA_SET  = 5'd17;
	localparam logic [PH_W-1:0] PH_RA_HIGH = 5'd18;
	localparam logic [PH_W-1:0] PH_RA_LOW  = 5'd19;

	typedef struct packed {
		logic       cmd_valid;
		logic [1:0] action;
		logic [7:0] tx_byte;
		logic       send_ack;
		logic       sda_in;
	} cmd_t;

	typedef struct packed {
		logic       scl;
		logic       sda_out;
		logic       sda_drive_enable;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_seen;
	} res_t;

endpackage

// ===== src/i2cm_if.sv =====
interface i2cm_cmd_if;
	logic       valid;
	logic       ready;
	logic       cmd_valid;
	logic [1:0] action;
	logic [7:0] tx_byte;
	logic       send_ack;
	logic       sda_in;

	modport source (output valid, cmd_valid, action, tx_byte, send_ack, sda_in, input ready);
	modport sink (input valid, cmd_valid, action, tx_byte, send_ack, sda_in, output ready);
endinterface

interface i2cm_res_if;
	logic       valid;
	logic       ready;
	logic       scl;
	logic       sda_out;
	logic       sda_drive_enable;
	logic       busy_res;
	logic       done_res;
	logic [7:0] rx_byte;
	logic       ack_seen;

	modport source (output valid, scl, sda_out, sda_drive_enable, busy_res, done_res, rx_byte,
		ack_seen, input ready);
	modport sink (input valid, scl, sda_out, sda_drive_enable, busy_res, done_res, rx_byte,
		ack_seen, output ready);
endinterface

// ===== src/i2cm_phase.sv =====
`include "assert_macros.svh"

module i2cm_phase (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  i2cm_pkg::cmd_t               item,
	input  logic [i2cm_pkg::CFG_W-1:0]   start_ticks,
	input  logic [i2cm_pkg::CFG_W-1:0]   bit_ticks,
	output i2cm_pkg::res_t               res
);

	logic [i2cm_pkg::PH_W-1:0]  phase_q, phase_n, tgt;
	logic [3:0]                 bit_count_q, bit_count_n;
	logic [7:0]                 shift_q, shift_n;
	logic [i2cm_pkg::CFG_W-1:0] delay_q, delay_n, len;
	logic                       ack_choice_q, ack_choice_n;
	logic                       scl_q, scl_n;
	logic                       sda_q, sda_n;
	logic                       sda_en_q, sda_en_n;
	logic                       ack_q, ack_n;
	logic [7:0]                 rx_q, rx_n;
	logic                       go;
	logic                       done;

	always_comb begin
		phase_n      = phase_q;
		bit_count_n  = bit_count_q;
		shift_n      = shift_q;
		delay_n      = delay_q;
		ack_choice_n = ack_choice_q;
		scl_n        = scl_q;
		sda_n        = sda_q;
		sda_en_n     = sda_en_q;
		ack_n        = ack_q;
		rx_n         = rx_q;
		tgt          = i2cm_pkg::PH_IDLE;
		go           = 1'b0;
		done         = 1'b0;
		len          = '0;

		if (phase_q == i2cm_pkg::PH_IDLE) begin
			if (item.cmd_valid) begin
				ack_choice_n = item.send_ack;
				bit_count_n  = 4'd0;
				go           = 1'b1;
				unique case (item.action)
					i2cm_pkg::ACT_START: tgt = i2cm_pkg::PH_ST_A;
					i2cm_pkg::ACT_STOP:  tgt = i2cm_pkg::PH_SP_A;
					i2cm_pkg::ACT_WRITE: begin
						shift_n = item.tx_byte;
						tgt     = i2cm_pkg::PH_WR_SET;
					end
					i2cm_pkg::ACT_READ: begin
						shift_n = 8'd0;
						tgt     = i2cm_pkg::PH_RD_HIGH;
					end
				endcase
			end
		end else if (delay_q != '0) begin
			delay_n = delay_q - 1'b1;
		end else begin
			unique case (phase_q) inside
				i2cm_pkg::PH_ST_D, i2cm_pkg::PH_SP_D, i2cm_pkg::PH_WA_LOW,
				i2cm_pkg::PH_RA_LOW: tgt = i2cm_pkg::PH_IDLE;
				i2cm_pkg::PH_WR_LOW:
					tgt = (bit_count_q < 4'd8) ? i2cm_pkg::PH_WR_SET : i2cm_pkg::PH_WA_REL;
				i2cm_pkg::PH_RD_LOW:
					tgt = (bit_count_q < 4'd8) ? i2cm_pkg::PH_RD_HIGH : i2cm_pkg::PH_RA_SET;
				default:
					tgt = (phase_q >= i2cm_pkg::PH_ST_A && phase_q < i2cm_pkg::PH_RA_LOW) ?
						phase_q + 5'd1 : i2cm_pkg::PH_IDLE;
			endcase
			if (tgt == i2cm_pkg::PH_IDLE) begin
				phase_n = i2cm_pkg::PH_IDLE;
				delay_n = '0;
				done    = 1'b1;
			end else begin
				go = 1'b1;
			end
		end

		if (go) begin
			phase_n = tgt;
			unique case (tgt)
				i2cm_pkg::PH_ST_A: begin
					sda_en_n = 1'b1;
					sda_n    = 1'b1;
				end
				i2cm_pkg::PH_ST_B:    scl_n = 1'b1;
				i2cm_pkg::PH_ST_C:    sda_n = 1'b0;
				i2cm_pkg::PH_ST_D:    scl_n = 1'b0;
				i2cm_pkg::PH_SP_A: begin
					sda_en_n = 1'b1;
					sda_n    = 1'b0;
				end
				i2cm_pkg::PH_SP_B:    scl_n = 1'b1;
				i2cm_pkg::PH_SP_C:    sda_n = 1'b1;
				i2cm_pkg::PH_SP_D:    scl_n = 1'b0;
				i2cm_pkg::PH_WR_SET: begin
					sda_en_n    = 1'b1;
					scl_n       = 1'b0;
					sda_n       = shift_n[7];
					shift_n     = {shift_n[6:0], 1'b0};
					bit_count_n = bit_count_n + 4'd1;
				end
				i2cm_pkg::PH_WR_HIGH: scl_n = 1'b1;
				i2cm_pkg::PH_WR_LOW:  scl_n = 1'b0;
				i2cm_pkg::PH_WA_REL: begin
					sda_en_n = 1'b0;
					sda_n    = 1'b1;
				end
				i2cm_pkg::PH_WA_HIGH: begin
					scl_n = 1'b1;
					ack_n = ~item.sda_in;
				end
				i2cm_pkg::PH_WA_LOW:  scl_n = 1'b0;
				i2cm_pkg::PH_RD_HIGH: begin
					sda_en_n    = 1'b0;
					scl_n       = 1'b1;
					shift_n     = {shift_n[6:0], item.sda_in};
					bit_count_n = bit_count_n + 4'd1;
				end
				i2cm_pkg::PH_RD_LOW:  scl_n = 1'b0;
				i2cm_pkg::PH_RA_SET: begin
					rx_n     = shift_n;
					sda_en_n = 1'b1;
					scl_n    = 1'b0;
					sda_n    = ~ack_choice_n;
				end
				i2cm_pkg::PH_RA_HIGH: scl_n = 1'b1;
				i2cm_pkg::PH_RA_LOW:  scl_n = 1'b0;
				default: ;
			endcase
			len     = (tgt >= i2cm_pkg::PH_ST_A && tgt <= i2cm_pkg::PH_ST_D) ?
				start_ticks : bit_ticks;
			delay_n = (len == '0) ? '0 : len - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= i2cm_pkg::PH_IDLE;
			bit_count_q  <= 4'd0;
			shift_q      <= 8'd0;
			delay_q      <= '0;
			ack_choice_q <= 1'b0;
			scl_q        <= 1'b0;
			sda_q        <= 1'b1;
			sda_en_q     <= 1'b1;
			ack_q        <= 1'b0;
			rx_q         <= 8'd0;
		end else if (step) begin
			phase_q      <= phase_n;
			bit_count_q  <= bit_count_n;
			shift_q      <= shift_n;
			delay_q      <= delay_n;
			ack_choice_q <= ack_choice_n;
			scl_q        <= scl_n;
			sda_q        <= sda_n;
			sda_en_q     <= sda_en_n;
			ack_q        <= ack_n;
			rx_q         <= rx_n;
		end
	end

	always_comb begin
		res.scl              = scl_n;
		res.sda_out          = sda_n;
		res.sda_drive_enable = sda_en_n;
		res.busy_res         = (phase_n != i2cm_pkg::PH_IDLE);
		res.done_res         = done;
		res.rx_byte          = rx_n;
		res.ack_seen         = ack_n;
	end

	`CHK_ALWAYS(a_bit_count_max, bit_count_q <= 4'd8, "bit count beyond eight")
	`CHK_NEVER(a_idle_scl_high, phase_q == i2cm_pkg::PH_IDLE && scl_q, "SCL high while idle")
	`CHK_ALWAYS(a_phase_hold,
		step && phase_q != i2cm_pkg::PH_IDLE && delay_q != '0 |=> phase_q == $past(phase_q),
		"phase left before its delay ran out")
	`CHK_NEVER(a_done_busy, step && res.done_res && res.busy_res, "done while still busy")

endmodule

// ===== src/i2c_master_byte_engine_top.sv =====
// I2C master byte engine.
// cmd channel: one word per timer tick, carrying cmd_valid, action, tx_byte,
// send_ack and the sampled SDA pin level. A command word is taken only when
// the engine is idle; one offered while a command runs is dropped.
// res channel: exactly one word per cmd word, with the SCL/SDA drive levels,
// busy, a done pulse, the last received byte and the last write acknowledge.
// Config: cfg_we writes cfg_wdata into register cfg_index (0 start phase
// ticks, 1 bit phase ticks); other indexes are ignored. Write only while idle.
// An accepted cmd word waits in the input register for the phase machine;
// its res word is then held in the result register, so a word can be accepted
// while the previous result waits. Throughput: one word per cycle while the
// receiver takes results. Phase lengths count in words, not clock cycles.
// Reset: idle, SCL low, SDA driven high, phase lengths 4 and 6 ticks.
// When the receiver stalls, the result register holds, the input register
// fills, and cmd.ready drops until the result is taken.
module i2c_master_byte_engine_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [i2cm_pkg::CFG_W-1:0] cfg_wdata,
	i2cm_cmd_if.sink                   cmd,
	i2cm_res_if.source                 res
);

	logic [i2cm_pkg::CFG_W-1:0] start_ticks_q;
	logic [i2cm_pkg::CFG_W-1:0] bit_ticks_q;
	i2cm_pkg::cmd_t             item_s1;
	logic                       v_s1;
	i2cm_pkg::res_t             res_n;
	i2cm_pkg::res_t             res_s2;
	logic                       v_s2;
	logic                       adv;
	logic                       step;

	assign adv       = !v_s2 || res.ready;
	assign step      = v_s1 && adv;
	assign cmd.ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_ticks_q <= 16'd4;
			bit_ticks_q   <= 16'd6;
		end else if (cfg_we && cfg_index[1] == 1'b0) begin
			if (cfg_index[0] == i2cm_pkg::REG_START_TICKS) begin
				start_ticks_q <= cfg_wdata;
			end else if (cfg_index[0] == i2cm_pkg::REG_BIT_TICKS) begin
				bit_ticks_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (cmd.ready) begin
			v_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			item_s1.cmd_valid <= cmd.cmd_valid;
			item_s1.action    <= cmd.action;
			item_s1.tx_byte   <= cmd.tx_byte;
			item_s1.send_ack  <= cmd.send_ack;
			item_s1.sda_in    <= cmd.sda_in;
		end
	end

	i2cm_phase u_phase (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.item        (item_s1),
		.start_ticks (start_ticks_q),
		.bit_ticks   (bit_ticks_q),
		.res         (res_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (step) begin
			v_s2 <= 1'b1;
		end else if (res.ready) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= res_n;
		end
	end

	assign res.valid            = v_s2;
	assign res.scl              = res_s2.scl;
	assign res.sda_out          = res_s2.sda_out;
	assign res.sda_drive_enable = res_s2.sda_drive_enable;
	assign res.busy_res         = res_s2.busy_res;
	assign res.done_res         = res_s2.done_res;
	assign res.rx_byte          = res_s2.rx_byte;
	assign res.ack_seen         = res_s2.ack_seen;

	`CHK_ALWAYS(a_s1_hold, v_s1 && !adv |=> v_s1 && $stable(item_s1),
		"input word lost under stall")
	`CHK_ALWAYS(a_step_fills, step |=> v_s2, "result register not loaded")
	`CHK_NEVER(a_done_busy_out, v_s2 && res_s2.done_res && res_s2.busy_res,
		"result shows done and busy")

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import i2cm_pkg::*;

	localparam logic [1:0] REG_SPARE_2 = 2'd2;
	localparam logic [1:0] REG_SPARE_3 = 2'd3;
	localparam int LATENCY = 6;
	localparam int STALL_LIMIT = 4000;

	typedef struct {
		cmd_t w;
		bit   busy_cmds;
		bit   typed;
		res_t lv;
	} step_row_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [1:0]          cfg_index;
	logic [CFG_W-1:0]    cfg_wdata;

	i2cm_cmd_if cmd ();
	i2cm_res_if res ();

	i2c_master_byte_engine_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.res       (res)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// engine mirror
	logic [15:0] m_start_len;
	logic [15:0] m_bit_len;
	logic [4:0]  m_phase;
	logic [3:0]  m_bits;
	logic [7:0]  m_shift;
	logic [15:0] m_delay;
	logic        m_ack_choice;
	logic        m_scl;
	logic        m_sda;
	logic        m_sda_en;
	logic        m_ack;
	logic [7:0]  m_rx;

	res_t      due_levels [$];
	int        errors;
	int        snd_idle_pct;
	int        rcv_idle_pct;
	int        quiet_cycles;
	bit        cmd_fire_n;
	bit        res_fire_n;
	res_t      res_word_n;
	step_row_t script [14];

	function automatic void enter_phase(input logic [4:0] p, input logic pin);
		logic [15:0] len;
		m_phase = p;
		case (p)
			PH_ST_A: begin m_sda_en = 1'b1; m_sda = 1'b1; end
			PH_ST_B: m_scl = 1'b1;
			PH_ST_C: m_sda = 1'b0;
			PH_ST_D: m_scl = 1'b0;
			PH_SP_A: begin m_sda_en = 1'b1; m_sda = 1'b0; end
			PH_SP_B: m_scl = 1'b1;
			PH_SP_C: m_sda = 1'b1;
			PH_SP_D: m_scl = 1'b0;
			PH_WR_SET: begin
				m_sda_en = 1'b1;
				m_scl = 1'b0;
				m_sda = m_shift[7];
				m_shift = {m_shift[6:0], 1'b0};
				m_bits = m_bits + 4'd1;
			end
			PH_WR_HIGH: m_scl = 1'b1;
			PH_WR_LOW: m_scl = 1'b0;
			PH_WA_REL: begin m_sda_en = 1'b0; m_sda = 1'b1; end
			PH_WA_HIGH: begin m_scl = 1'b1; m_ack = ~pin; end
			PH_WA_LOW: m_scl = 1'b0;
			PH_RD_HIGH: begin
				m_sda_en = 1'b0;
				m_scl = 1'b1;
				m_shift = {m_shift[6:0], pin};
				m_bits = m_bits + 4'd1;
			end
			PH_RD_LOW: m_scl = 1'b0;
			PH_RA_SET: begin
				m_rx = m_shift;
				m_sda_en = 1'b1;
				m_scl = 1'b0;
				m_sda = ~m_ack_choice;
			end
			PH_RA_HIGH: m_scl = 1'b1;
			PH_RA_LOW: m_scl = 1'b0;
			default: ;
		endcase
		len = (p >= PH_ST_A && p <= PH_ST_D) ? m_start_len : m_bit_len;
		m_delay = (len == 16'd0) ? 16'd0 : len - 16'd1;
	endfunction

	function automatic res_t advance_engine(input cmd_t w);
		logic [4:0] nxt;
		logic       done;
		res_t       r;
		done = 1'b0;
		if (m_phase == PH_IDLE) begin
			if (w.cmd_valid) begin
				m_ack_choice = w.send_ack;
				m_bits = 4'd0;
				case (w.action)
					ACT_START: enter_phase(PH_ST_A, w.sda_in);
					ACT_STOP: enter_phase(PH_SP_A, w.sda_in);
					ACT_WRITE: begin
						m_shift = w.tx_byte;
						enter_phase(PH_WR_SET, w.sda_in);
					end
					ACT_READ: begin
						m_shift = 8'd0;
						enter_phase(PH_RD_HIGH, w.sda_in);
					end
				endcase
			end
		end else if (m_delay != 16'd0) begin
			m_delay = m_delay - 16'd1;
		end else begin
			case (m_phase)
				PH_ST_D, PH_SP_D, PH_WA_LOW, PH_RA_LOW: nxt = PH_IDLE;
				PH_WR_LOW: nxt = (m_bits < 4'd8) ? PH_WR_SET : PH_WA_REL;
				PH_RD_LOW: nxt = (m_bits < 4'd8) ? PH_RD_HIGH : PH_RA_SET;
				default: nxt = m_phase + 5'd1;
			endcase
			if (nxt == PH_IDLE) begin
				m_phase = PH_IDLE;
				m_delay = 16'd0;
				done = 1'b1;
			end else begin
				enter_phase(nxt, w.sda_in);
			end
		end
		r.scl = m_scl;
		r.sda_out = m_sda;
		r.sda_drive_enable = m_sda_en;
		r.busy_res = (m_phase != PH_IDLE);
		r.done_res = done;
		r.rx_byte = m_rx;
		r.ack_seen = m_ack;
		return r;
	endfunction

	function automatic cmd_t random_word();
		cmd_t w;
		w.cmd_valid = 1'($urandom_range(1));
		w.action = 2'($urandom_range(3));
		w.tx_byte = 8'($urandom_range(255));
		w.send_ack = 1'($urandom_range(1));
		w.sda_in = 1'($urandom_range(1));
		return w;
	endfunction

	task automatic drive(input cmd_t w);
		cmd.cmd_valid <= w.cmd_valid;
		cmd.action <= w.action;
		cmd.tx_byte <= w.tx_byte;
		cmd.send_ack <= w.send_ack;
		cmd.sda_in <= w.sda_in;
	endtask

	task automatic push_word(input cmd_t w, input bit typed, input res_t lv);
		res_t p;
		while ($urandom_range(99) < snd_idle_pct) begin
			cmd.valid <= 1'b0;
			drive(random_word());
			@(posedge clk);
		end
		cmd.valid <= 1'b1;
		drive(w);
		@(posedge clk);
		while (!cmd_fire_n)
			@(posedge clk);
		p = advance_engine(w);
		due_levels.push_back(typed ? lv : p);
	endtask

	task automatic hold_until_drained();
		cmd.valid <= 1'b0;
		@(posedge clk);
		while (due_levels.size() != 0)
			@(posedge clk);
	endtask

	task automatic settle();
		cmd_t w;
		while (m_phase != PH_IDLE) begin
			w = random_word();
			w.cmd_valid = 1'b0;
			push_word(w, 1'b0, '0);
		end
		hold_until_drained();
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic set_lengths(input logic [15:0] s, input logic [15:0] b, input bit stray);
		cfg_we <= 1'b1;
		cfg_index <= {1'b0, REG_START_TICKS};
		cfg_wdata <= s;
		@(posedge clk);
		cfg_index <= {1'b0, REG_BIT_TICKS};
		cfg_wdata <= b;
		@(posedge clk);
		if (stray) begin
			cfg_index <= REG_SPARE_2;
			cfg_wdata <= 16'($urandom_range(16'hFFFF));
			@(posedge clk);
			cfg_index <= REG_SPARE_3;
			cfg_wdata <= 16'($urandom_range(16'hFFFF));
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		m_start_len = s;
		m_bit_len = b;
		@(posedge clk);
	endtask

	task automatic run_random(input int budget);
		int   counted;
		bit   idle_now;
		cmd_t w;
		counted = 0;
		while (counted < budget) begin
			idle_now = (m_phase == PH_IDLE);
			w = random_word();
			w.cmd_valid = idle_now ? ($urandom_range(99) < 85) : ($urandom_range(99) < 20);
			if (!(w.cmd_valid && !idle_now))
				counted++;
			push_word(w, 1'b0, '0);
			if ($urandom_range(299) == 0)
				hold_until_drained();
		end
	endtask

	task automatic note_mismatch(input string what, input int e, input int a);
		errors++;
		$display("%0t: %s expected %0h got %0h", $time, what, e, a);
	endtask

	always @(negedge clk) begin
		cmd_fire_n = cmd.valid && cmd.ready;
		res_fire_n = res.valid && res.ready;
		res_word_n = {res.scl, res.sda_out, res.sda_drive_enable, res.busy_res,
			res.done_res, res.rx_byte, res.ack_seen};
	end

	always @(posedge clk)
		res.ready <= ($urandom_range(99) >= rcv_idle_pct);

	always @(posedge clk) begin : check_levels
		res_t e;
		if (arst_n) begin
			if (res_fire_n) begin
				if (due_levels.size() == 0) begin
					errors++;
					$display("%0t: unexpected word expected none got %0h", $time, res_word_n);
				end else begin
					e = due_levels.pop_front();
					if (res_word_n.scl !== e.scl)
						note_mismatch("scl", e.scl, res_word_n.scl);
					if (res_word_n.sda_out !== e.sda_out)
						note_mismatch("sda_out", e.sda_out, res_word_n.sda_out);
					if (res_word_n.sda_drive_enable !== e.sda_drive_enable)
						note_mismatch("sda_drive_enable", e.sda_drive_enable,
							res_word_n.sda_drive_enable);
					if (res_word_n.busy_res !== e.busy_res)
						note_mismatch("busy_res", e.busy_res, res_word_n.busy_res);
					if (res_word_n.done_res !== e.done_res)
						note_mismatch("done_res", e.done_res, res_word_n.done_res);
					if (res_word_n.rx_byte !== e.rx_byte)
						note_mismatch("rx_byte", e.rx_byte, res_word_n.rx_byte);
					if (res_word_n.ack_seen !== e.ack_seen)
						note_mismatch("ack_seen", e.ack_seen, res_word_n.ack_seen);
				end
			end
			if (cmd_fire_n || res_fire_n)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin : stimulus
		cmd_t w;
		errors = 0;
		quiet_cycles = 0;
		snd_idle_pct = 27;
		rcv_idle_pct = 49;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = {1'b0, REG_START_TICKS};
		cfg_wdata = '0;
		cmd.valid = 1'b0;
		cmd.cmd_valid = 1'b0;
		cmd.action = ACT_START;
		cmd.tx_byte = 8'h00;
		cmd.send_ack = 1'b0;
		cmd.sda_in = 1'b1;
		res.ready = 1'b0;
		m_start_len = 16'd4;
		m_bit_len = 16'd6;
		m_phase = PH_IDLE;
		m_bits = 4'd0;
		m_shift = 8'd0;
		m_delay = 16'd0;
		m_ack_choice = 1'b0;
		m_scl = 1'b0;
		m_sda = 1'b1;
		m_sda_en = 1'b1;
		m_ack = 1'b0;
		m_rx = 8'd0;

		script = '{
			'{{1'b0, ACT_START, 8'h00, 1'b0, 1'b0}, 1'b0, 1'b1,
				{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0}},
			'{{1'b1, ACT_START, 8'h00, 1'b0, 1'b0}, 1'b0, 1'b1,
				{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0}},
			'{{1'b1, ACT_STOP, 8'h00, 1'b0, 1'b1}, 1'b0, 1'b0, '0},
			'{{1'b1, ACT_WRITE, 8'hFF, 1'b0, 1'b0}, 1'b0, 1'b1,
				{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0}},
			'{{1'b1, ACT_WRITE, 8'h00, 1'b1, 1'b1}, 1'b0, 1'b0, '0},
			'{{1'b1, ACT_WRITE, 8'hA5, 1'b0, 1'b0}, 1'b0, 1'b0, '0},
			'{{1'b1, ACT_WRITE, 8'h80, 1'b1, 1'b1}, 1'b0, 1'b0, '0},
			'{{1'b1, ACT_READ, 8'h00, 1'b1, 1'b1}, 1'b0, 1'b0, '0},
			'{{1'b1, ACT_READ, 8'hFF, 1'b0, 1'b0}, 1'b0, 1'b0, '0},
			'{{1'b1, ACT_START, 8'h00, 1'b0, 1'b1}, 1'b1, 1'b0, '0},
			'{{1'b1, ACT_WRITE, 8'h01, 1'b0, 1'b0}, 1'b1, 1'b0, '0},
			'{{1'b1, ACT_READ, 8'h5A, 1'b1, 1'b0}, 1'b1, 1'b0, '0},
			'{{1'b1, ACT_STOP, 8'hFF, 1'b1, 1'b0}, 1'b1, 1'b0, '0},
			'{{1'b0, ACT_READ, 8'hFF, 1'b1, 1'b1}, 1'b0, 1'b0, '0}
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows at reset phase lengths; fill each command out to idle
		foreach (script[i]) begin
			push_word(script[i].w, script[i].typed, script[i].lv);
			while (m_phase != PH_IDLE) begin
				w = random_word();
				w.cmd_valid = script[i].busy_cmds;
				w.sda_in = script[i].w.sda_in;
				push_word(w, 1'b0, '0);
			end
		end
		settle();

		set_lengths(16'd1, 16'd1, 1'b0);
		run_random(200);
		settle();

		snd_idle_pct = 49;
		rcv_idle_pct = 27;
		set_lengths(16'd0, 16'd0, 1'b1);
		run_random(150);
		settle();

		set_lengths(16'd3, 16'd2, 1'b1);
		run_random(100);
		settle();

		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		set_lengths(16'hFFFF, 16'd1, 1'b0);
		push_word({1'b1, ACT_STOP, 8'hC3, 1'b0, 1'b1}, 1'b0, '0);
		settle();
		push_word({1'b1, ACT_WRITE, 8'h3C, 1'b1, 1'b0}, 1'b0, '0);
		settle();

		set_lengths(16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)), 1'b1);
		run_random(100);
		settle();

		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
